/* sv/calendar_day_stepper_match_counter_unit_defines.svh */
// Assertion helpers for the checker file.
`ifndef CALENDAR_DAY_STEPPER_MATCH_COUNTER_UNIT_DEFINES_SVH
`define CALENDAR_DAY_STEPPER_MATCH_COUNTER_UNIT_DEFINES_SVH

// Same-cycle implication, held off while reset is high.
`define CDSMC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cdsmc assertion failed");

// Next-cycle implication, held off while reset is high.
`define CDSMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cdsmc assertion failed");

`endif

/* sv/cdsmc_pkg.sv */
package cdsmc_pkg;

   localparam int YearWidth   = 14;
   localparam int MonthWidth  = 4;
   localparam int DayWidth    = 5;
   localparam int WdayWidth   = 3;
   localparam int PackedWidth = YearWidth + MonthWidth + DayWidth;
   localparam int CountWidth  = 32;
   localparam int CsrIndexWidth = 3;

   // y is a multiple of 25 exactly when (y * inverse of 25) mod 2^14 stays
   // at or below floor((2^14 - 1) / 25).
   localparam logic [YearWidth-1:0] Inv25Mod   = 14'd7209;
   localparam logic [YearWidth-1:0] Div25Limit = 14'd655;

   localparam logic [PackedWidth-1:0] StartDateReset = 23'd973345;
   localparam logic [PackedWidth-1:0] EndDateReset   = 23'd1024415;
   localparam logic [WdayWidth-1:0]   StartWdayReset = 3'd1;
   localparam logic [DayWidth-1:0]    TargetDayReset = 5'd1;
   localparam logic [WdayWidth-1:0]   TargetWdayReset = 3'd6;

   localparam logic [YearWidth-1:0]  YearReset  = 14'd1901;
   localparam logic [MonthWidth-1:0] MonthReset = 4'd1;
   localparam logic [DayWidth-1:0]   DayReset   = 5'd1;
   localparam logic [WdayWidth-1:0]  WdayReset  = 3'd1;

   localparam logic [MonthWidth:0]   LastMonth  = 5'd12;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_START_DATE  = 3'd0,
      CSR_END_DATE    = 3'd1,
      CSR_START_WDAY  = 3'd2,
      CSR_TARGET_DAY  = 3'd3,
      CSR_TARGET_WDAY = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [YearWidth-1:0]  year;
      logic [MonthWidth-1:0] month;
      logic [DayWidth-1:0]   day;
      logic [WdayWidth-1:0]  weekday;
   } date_type;

   typedef struct packed {
      logic in_range;
      logic hit;
   } step_flags_type;

   function automatic logic is_leap(input logic [YearWidth-1:0] y);
      logic [YearWidth-1:0] prod;
      logic by25;
      prod = y * Inv25Mod;
      by25 = (prod <= Div25Limit);
      return (y[1:0] == 2'd0) && (!by25 || (y[3:0] == 4'd0));
   endfunction

   function automatic logic [DayWidth-1:0] month_len(input logic [YearWidth-1:0] y,
                                                     input logic [MonthWidth-1:0] m);
      logic [DayWidth-1:0] len;
      len = 5'd31;
      if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
         len = 5'd30;
      end else if (m == 4'd2) begin
         len = is_leap(y) ? 5'd29 : 5'd28;
      end
      return len;
   endfunction

endpackage

/* sv/calendar_day_stepper_match_counter_unit.sv */
// Latency: a result is valid the cycle after its request transfer.
// Throughput: one request per cycle unless a held result waits on rsp_ready;
// the day step, range compare and match test feed the registers that hold it.
// Reset: synchronous, active high; the date returns to 1901-01-01 (Tuesday),
// the match count to zero and all configuration registers to their defaults.
module calendar_day_stepper_match_counter_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_restart,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [cdsmc_pkg::YearWidth-1:0]         rsp_out_year,
   output logic [cdsmc_pkg::MonthWidth-1:0]        rsp_out_month,
   output logic [cdsmc_pkg::DayWidth-1:0]          rsp_out_day_of_month,
   output logic [cdsmc_pkg::WdayWidth-1:0]         rsp_out_weekday,
   output logic [cdsmc_pkg::CountWidth-1:0]        rsp_match_total,
   output logic                                    rsp_in_range,
   output logic                                    rsp_matched,
   input  logic                                    csr_write_enable,
   input  logic [cdsmc_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [cdsmc_pkg::PackedWidth-1:0]       csr_write_data
);
   import cdsmc_pkg::*;

   logic [PackedWidth-1:0] start_date_ff;
   logic [PackedWidth-1:0] stop_date_ff;
   logic [WdayWidth-1:0]   start_wday_ff;
   logic [DayWidth-1:0]    match_day_ff;
   logic [WdayWidth-1:0]   target_wday_ff;

   date_type               date_ff, date_in, date_step;
   step_flags_type         flags_ff, flags_in, flags_step;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   valid_ff;
   logic                   take;

   assign req_ready = !reset && (!valid_ff || rsp_ready);
   assign take      = req_valid && req_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_date_ff  <= StartDateReset;
         stop_date_ff   <= EndDateReset;
         start_wday_ff  <= StartWdayReset;
         match_day_ff   <= TargetDayReset;
         target_wday_ff <= TargetWdayReset;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_START_DATE:  start_date_ff  <= csr_write_data;
            CSR_END_DATE:    stop_date_ff   <= csr_write_data;
            CSR_START_WDAY:  start_wday_ff  <= csr_write_data[WdayWidth-1:0];
            CSR_TARGET_DAY:  match_day_ff   <= csr_write_data[DayWidth-1:0];
            CSR_TARGET_WDAY: target_wday_ff <= csr_write_data[WdayWidth-1:0];
            default: ;
         endcase
      end
   end

   cdsmc_day_step u_day_step (
      .cur         (date_ff),
      .stop_date   (stop_date_ff),
      .match_day   (match_day_ff),
      .target_wday (target_wday_ff),
      .nxt         (date_step),
      .flags       (flags_step)
   );

   always_comb begin
      date_in  = date_ff;
      flags_in = '0;
      count_in = count_ff;
      if (req_restart) begin
         date_in.year    = start_date_ff[PackedWidth-1 -: YearWidth];
         date_in.month   = start_date_ff[DayWidth +: MonthWidth];
         date_in.day     = start_date_ff[DayWidth-1:0];
         date_in.weekday = start_wday_ff;
         count_in        = '0;
      end else if (flags_step.in_range) begin
         date_in  = date_step;
         flags_in = flags_step;
         // hold the count at its top value
         if (flags_step.hit && (count_ff != '1)) begin
            count_in = count_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         date_ff  <= '{year: YearReset, month: MonthReset, day: DayReset,
                       weekday: WdayReset};
         flags_ff <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (take) begin
            date_ff  <= date_in;
            flags_ff <= flags_in;
            count_ff <= count_in;
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_out_year         = date_ff.year;
   assign rsp_out_month        = date_ff.month;
   assign rsp_out_day_of_month = date_ff.day;
   assign rsp_out_weekday      = date_ff.weekday;
   assign rsp_match_total      = count_ff;
   assign rsp_in_range         = flags_ff.in_range;
   assign rsp_matched          = flags_ff.hit;

endmodule

/* sv/cdsmc_day_step.sv */
module cdsmc_day_step (
   input  cdsmc_pkg::date_type                        cur,
   input  logic [cdsmc_pkg::PackedWidth-1:0]          stop_date,
   input  logic [cdsmc_pkg::DayWidth-1:0]             match_day,
   input  logic [cdsmc_pkg::WdayWidth-1:0]            target_wday,
   output cdsmc_pkg::date_type                        nxt,
   output cdsmc_pkg::step_flags_type                  flags
);
   import cdsmc_pkg::*;

   logic [PackedWidth-1:0] now;
   logic [DayWidth:0]      day_inc;
   logic                   roll;
   logic [MonthWidth:0]    month_adv;

   assign now       = {cur.year, cur.month, cur.day};
   assign day_inc   = {1'b0, cur.day} + 6'd1;
   assign roll      = day_inc > {1'b0, month_len(cur.year, cur.month)};
   assign month_adv = roll ? ({1'b0, cur.month} + 5'd1) : {1'b0, cur.month};

   always_comb begin
      flags.in_range = now < stop_date;
      flags.hit      = flags.in_range && (cur.day == match_day)
                       && (cur.weekday == target_wday);

      nxt.day = roll ? DayReset : day_inc[DayWidth-1:0];
      // any month past December wraps into January of the next year
      if (month_adv > LastMonth) begin
         nxt.month = MonthReset;
         nxt.year  = cur.year + 14'd1;
      end else begin
         nxt.month = month_adv[MonthWidth-1:0];
         nxt.year  = cur.year;
      end

      case (cur.weekday)
         3'd6:    nxt.weekday = 3'd0;
         3'd7:    nxt.weekday = 3'd1;
         default: nxt.weekday = cur.weekday + 3'd1;
      endcase
   end

endmodule

/* sv/cdsmc_checker.sv */
`include "calendar_day_stepper_match_counter_unit_defines.svh"

module cdsmc_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_ready,
   input logic                                    req_restart,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic [cdsmc_pkg::MonthWidth-1:0]        rsp_out_month,
   input logic [cdsmc_pkg::DayWidth-1:0]          rsp_out_day_of_month,
   input logic [cdsmc_pkg::WdayWidth-1:0]         rsp_out_weekday,
   input logic [cdsmc_pkg::CountWidth-1:0]        rsp_match_total,
   input logic                                    rsp_in_range,
   input logic                                    rsp_matched
);

   // a stalled result keeps its count
   `CDSMC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_match_total))

   // restart transfer clears the count and both flags
   `CDSMC_ASSERT_NEXT(a_restart_clears, clock, reset, req_valid && req_ready && req_restart,
      rsp_valid && (rsp_match_total == '0) && !rsp_in_range && !rsp_matched)

   // a match only happens on an advancing tick
   `CDSMC_ASSERT_NOW(a_match_in_range, clock, reset, rsp_valid && rsp_matched, rsp_in_range)

   // after an advance the month is at most December, the weekday is real
   // and the day is nonzero
   `CDSMC_ASSERT_NOW(a_advance_legal, clock, reset, rsp_valid && rsp_in_range,
      (rsp_out_month <= 4'd12) && (rsp_out_weekday != 3'd7) && (rsp_out_day_of_month != 5'd0))

endmodule

bind calendar_day_stepper_match_counter_unit cdsmc_checker u_cdsmc_checker (.*);
